// ===== src/cmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmd_pkg - shared types and constants for the call message deframer
// Holds the header geometry and the result beat layout used by the framer
// and its output buffer.
// ----------------------------------------------------------------------------
package cmd_pkg;

    // Header size in bytes (supported range 16 to 255).
    localparam int unsigned HEADER_BYTES = 48;

    // Header byte offsets.
    localparam logic [31:0] POS_LEN_B0  = 32'd0;
    localparam logic [31:0] POS_LEN_B1  = 32'd1;
    localparam logic [31:0] POS_LEN_B2  = 32'd2;
    localparam logic [31:0] POS_LEN_B3  = 32'd3;
    localparam logic [31:0] POS_ARG_CNT = 32'd10;
    localparam logic [31:0] POS_ARG_IDX = 32'd11;
    localparam logic [31:0] POS_HDR_END = 32'(HEADER_BYTES - 1);
    localparam logic [31:0] HDR_LEN     = 32'(HEADER_BYTES);

    typedef struct packed {
        logic [7:0] byte_out;
        logic       message_end;
        logic       call_end;
        logic       malformed;
    } cmd_result_t;

endpackage

// ===== src/cmd_out_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmd_out_buffer - two-entry registered output buffer
// Output register plus a skid entry, so an input beat can be taken while a
// result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module cmd_out_buffer
    import cmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output cmd_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    cmd_result_t out_reg, out_next;
    cmd_result_t skid_reg, skid_next;
    logic        push, pop;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign push      = in_valid & ~skid_valid_reg;
    assign pop       = out_valid_reg & out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = in_data;
            end
        end else if (!out_valid_reg) begin
            out_valid_next = push;
            out_next       = in_data;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== src/call_message_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_message_deframer - byte stream message and call framer
// Usage:
//   s_ channel: one raw stream byte per beat on s_data_byte.
//   m_ channel: one result beat per input beat, in order: the byte itself,
//   message_end on the last byte of a message, call_end on the last byte of
//   the last message of a call, and the sticky malformed flag.
//   Each message opens with a header: little-endian length at bytes 0-3,
//   argument count at byte 10, descriptor index at byte 11.
//   Output: each result is registered in the output buffer before it is presented.
//   Throughput: one byte per cycle while s_ready is high; the framing counter compare
//   and header capture all settle in the accept cycle.
//   Stall: a two-entry output buffer lets one more byte in while a result
//   waits; s_ready drops only when both entries are full.
//   Reset (aresetn low, synchronous): position, header fields and the
//   malformed flag clear; both buffer entries empty.
//   Malformed: a header with length below the header size sets malformed;
//   framing then stops until reset and bytes still pass through.
// ----------------------------------------------------------------------------
module call_message_deframer
    import cmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out,
    output logic       m_message_end,
    output logic       m_call_end,
    output logic       m_malformed
);

    // Framing state
    logic [31:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  arg_cnt_reg, arg_cnt_next;
    logic [7:0]  arg_idx_reg, arg_idx_next;
    logic        malformed_reg, malformed_next;

    logic        accept;
    logic        msg_end;
    logic        call_done;
    logic [32:0] pos_inc;
    cmd_result_t result;
    cmd_result_t out_beat;

    assign accept  = s_valid & s_ready;
    assign pos_inc = {1'b0, pos_reg} + 33'd1;

    always_comb begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        arg_cnt_next   = arg_cnt_reg;
        arg_idx_next   = arg_idx_reg;
        malformed_next = malformed_reg;
        msg_end        = 1'b0;
        call_done      = 1'b0;

        if (!malformed_reg) begin
            // Header capture; length lanes are bytes 0-3, byte 0 clears the rest
            case (pos_reg)
                POS_LEN_B0:  len_next = {24'd0, s_data_byte};
                POS_LEN_B1:  len_next = len_reg | {16'd0, s_data_byte, 8'd0};
                POS_LEN_B2:  len_next = len_reg | {8'd0, s_data_byte, 16'd0};
                POS_LEN_B3:  len_next = len_reg | {s_data_byte, 24'd0};
                POS_ARG_CNT: arg_cnt_next = s_data_byte;
                POS_ARG_IDX: arg_idx_next = s_data_byte;
                default:     ;
            endcase

            // Length is final well before the last header byte
            if (pos_reg == POS_HDR_END && len_reg < HDR_LEN) begin
                malformed_next = 1'b1;
            end else if (pos_reg >= POS_HDR_END && pos_inc == {1'b0, len_reg}) begin
                msg_end   = 1'b1;
                // index >= count - 1 (signed); zero count always completes
                call_done = (arg_cnt_reg == 8'd0) ||
                            (({1'b0, arg_idx_reg} + 9'd1) >= {1'b0, arg_cnt_reg});
                pos_next  = 32'd0;
            end else begin
                pos_next = pos_inc[31:0];   // advance within the message
            end
        end

        result.byte_out    = s_data_byte;
        result.message_end = msg_end;
        result.call_end    = call_done;
        result.malformed   = malformed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 32'd0;
            len_reg       <= 32'd0;
            arg_cnt_reg   <= 8'd0;
            arg_idx_reg   <= 8'd0;
            malformed_reg <= 1'b0;
        end else if (accept) begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            arg_cnt_reg   <= arg_cnt_next;
            arg_idx_reg   <= arg_idx_next;
            malformed_reg <= malformed_next;
        end
    end

    cmd_out_buffer u_out_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_beat)
    );

    assign m_byte_out    = out_beat.byte_out;
    assign m_message_end = out_beat.message_end;
    assign m_call_end    = out_beat.call_end;
    assign m_malformed   = out_beat.malformed;

endmodule

// ===== src/cmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmd_checker - port-level assertions for the call message deframer
// Checks result flag consistency, the sticky error and the buffer backpressure.
// ----------------------------------------------------------------------------
module cmd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_byte_out,
    input logic       m_message_end,
    input logic       m_call_end,
    input logic       m_malformed
);

    logic mal_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mal_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_malformed) begin
            mal_seen_reg <= 1'b1;
        end
    end

    // A call ends only on a message end
    a_call_in_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_call_end |-> m_message_end)
        else $error("call_end without message_end");

    // No framing marks once malformed
    a_mal_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_malformed |-> !m_message_end && !m_call_end)
        else $error("framing mark on a malformed beat");

    // Malformed stays set after it has been delivered
    a_mal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && mal_seen_reg |-> m_malformed)
        else $error("malformed flag cleared without reset");

    // Input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_out) &&
        $stable(m_message_end) && $stable(m_call_end) && $stable(m_malformed))
        else $error("result beat changed while stalled");

endmodule

bind call_message_deframer cmd_checker u_cmd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_byte_out    (m_byte_out),
    .m_message_end (m_message_end),
    .m_call_end    (m_call_end),
    .m_malformed   (m_malformed)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for call_message_deframer
// Streams framed messages into the s_ channel and checks every m_ beat against
// a local framing predictor: byte passthrough, message end, call end and the
// sticky malformed flag. A short table of hand-picked messages comes first,
// then random messages, then a short-length header and trailing noise (the
// malformed flag is sticky, so that case has to close the run).
// ----------------------------------------------------------------------------
module tb;
    import cmd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 100;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int HOLD_AFTER   = 150;   // beats checked before the hold-off
    localparam int NOISE_BYTES  = 24;
    localparam int TAIL_CYCLES  = 8;
    localparam int N_ROWS       = 6;

    // One message of the stimulus table. When pinned is set the flags of the
    // message's closing beat are typed in here rather than predicted.
    typedef struct {
        logic [31:0] len;
        logic [7:0]  count;
        logic [7:0]  index;
        logic        pinned;
        logic        msg_end;
        logic        call_end;
        logic        bad;
    } msg_row_t;

    // Directed messages. The last row (short length) is played after the
    // random part since malformed never clears without a reset.
    msg_row_t plan [0:N_ROWS-1] = '{
        '{32'd48,        8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 1'b0}, // after reset, header only
        '{32'd49,        8'd1,   8'd0,   1'b1, 1'b1, 1'b1, 1'b0}, // index == count - 1
        '{32'd48,        8'd2,   8'd0,   1'b1, 1'b1, 1'b0, 1'b0}, // call still open
        '{32'h0000_0100, 8'd255, 8'd253, 1'b1, 1'b1, 1'b0, 1'b0}, // length byte 1 set
        '{32'd48,        8'd0,   8'd255, 1'b1, 1'b1, 1'b1, 1'b0}, // zero count, max index
        '{32'd47,        8'd0,   8'd0,   1'b1, 1'b0, 1'b0, 1'b1}  // short length
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_byte_out;
    logic       m_message_end;
    logic       m_call_end;
    logic       m_malformed;

    // Typed-in flags travel with the payload so they line up with the beat.
    logic       pin_en;
    logic       pin_msg_end;
    logic       pin_call_end;
    logic       pin_bad;

    // Predictor state.
    logic [31:0] fr_pos   = '0;
    logic [31:0] fr_len   = '0;
    logic [7:0]  fr_count = '0;
    logic [7:0]  fr_index = '0;
    logic        fr_bad   = 1'b0;

    cmd_result_t framed_bytes [$];

    int mismatches     = 0;
    int beats_checked  = 0;
    int msg_ends_seen  = 0;
    int call_ends_seen = 0;
    int bad_beats_seen = 0;
    int cycles         = 0;

    call_message_deframer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_out    (m_byte_out),
        .m_message_end (m_message_end),
        .m_call_end    (m_call_end),
        .m_malformed   (m_malformed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Run guard: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d beats still owed",
                     $time, cycles, framed_bytes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(16, 60);
    endfunction

    // Framing predictor: advances the local state by one byte and returns
    // the beat the block should produce for it.
    task automatic frame_byte(input logic [7:0] b, output cmd_result_t r);
        logic [31:0] at;
        int          idx_s;
        int          cnt_s;
        at            = fr_pos;
        r.byte_out    = b;
        r.message_end = 1'b0;
        r.call_end    = 1'b0;
        if (!fr_bad) begin
            if (at == POS_LEN_B0)
                fr_len = {24'd0, b};
            else if (at <= POS_LEN_B3)
                fr_len[at*8 +: 8] = b;
            if (at == POS_ARG_CNT)
                fr_count = b;
            if (at == POS_ARG_IDX)
                fr_index = b;

            if (at == POS_HDR_END && fr_len < HDR_LEN) begin
                fr_bad = 1'b1;
            end else if (at >= POS_HDR_END && {1'b0, at} + 33'd1 == {1'b0, fr_len}) begin
                // count is compared signed: a zero count always closes a call
                idx_s         = int'(fr_index);
                cnt_s         = int'(fr_count);
                r.message_end = 1'b1;
                r.call_end    = (idx_s >= cnt_s - 1);
                fr_pos        = '0;
            end else begin
                fr_pos = at + 32'd1;
            end
        end
        r.malformed = fr_bad;
    endtask

    function automatic void diff_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
        end
    endfunction

    // Scoreboard. Input beats are predicted before output beats are taken
    // in the same edge, so ordering inside the time step never matters.
    always @(posedge aclk) begin : check_beats
        cmd_result_t want;
        cmd_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                frame_byte(s_data_byte, want);
                if (pin_en) begin
                    want.message_end = pin_msg_end;
                    want.call_end    = pin_call_end;
                    want.malformed   = pin_bad;
                end
                framed_bytes.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_byte_out, m_message_end, m_call_end, m_malformed};
                if (framed_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, actual %0h", $time, got);
                end else begin
                    want = framed_bytes.pop_front();
                    diff_field("byte_out",    want.byte_out,    got.byte_out);
                    diff_field("message_end", {7'd0, want.message_end},
                               {7'd0, got.message_end});
                    diff_field("call_end",    {7'd0, want.call_end},
                               {7'd0, got.call_end});
                    diff_field("malformed",   {7'd0, want.malformed},
                               {7'd0, got.malformed});
                    beats_checked++;
                    if (got.message_end) msg_ends_seen++;
                    if (got.call_end)    call_ends_seen++;
                    if (got.malformed)   bad_beats_seen++;
                end
            end
        end
    end

    // Result side: random stalls, ready-only stretches, and one long hold-off
    // that lets the two-entry buffer fill and push back on s_ready.
    initial begin : result_sink
        int  stall_left;
        int  free_left;
        int  hold_left;
        logic hold_done;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!hold_done && beats_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (free_left > 0) begin
                free_left--;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    free_left = $urandom_range(40, 160);
                else
                    stall_left = pick_gap();
            end
            @(posedge aclk);
        end
    end

    // Offer one byte and hold it until the beat is taken. A gap lowers valid
    // first; back-to-back bytes keep valid high across the edge.
    task automatic send_byte(input logic [7:0] b, input logic steady, input logic pin,
                             input logic pme, input logic pce, input logic pbad);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        pin_en       <= pin;
        pin_msg_end  <= pme;
        pin_call_end <= pce;
        pin_bad      <= pbad;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send a whole message; a short-length one stops at the header's end.
    task automatic send_message(input msg_row_t row, input logic steady,
                                output int sent);
        logic [31:0] last_pos;
        logic [31:0] p;
        logic [7:0]  b;
        last_pos = (row.len < HDR_LEN) ? POS_HDR_END : row.len - 32'd1;
        for (p = 32'd0; p <= last_pos; p++) begin
            case (p)
                POS_LEN_B0:  b = row.len[7:0];
                POS_LEN_B1:  b = row.len[15:8];
                POS_LEN_B2:  b = row.len[23:16];
                POS_LEN_B3:  b = row.len[31:24];
                POS_ARG_CNT: b = row.count;
                POS_ARG_IDX: b = row.index;
                default:     b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, steady, row.pinned && (p == last_pos),
                      row.msg_end, row.call_end, row.bad);
        end
        sent = int'(last_pos) + 1;
    endtask

    // Hold the source off until every owed beat has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (framed_bytes.size() != 0);
    endtask

    initial begin : stream_source
        msg_row_t row;
        int       sent;
        int       rand_bytes;
        int       n_msgs;
        int       k;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        pin_en       = 1'b0;
        pin_msg_end  = 1'b0;
        pin_call_end = 1'b0;
        pin_bad      = 1'b0;
        rand_bytes   = 0;
        n_msgs       = 0;
        while (aresetn !== 1'b1) @(posedge aclk);

        // directed messages, all but the short-length one
        for (k = 0; k < N_ROWS - 1; k++)
            send_message(plan[k], $urandom_range(0, 4) == 0, sent);

        // random well-formed messages: mostly near header size
        while (rand_bytes < RANDOM_BYTES) begin
            if (n_msgs == 1)
                drain_results();
            k = $urandom_range(0, 99);
            if (k < 80)
                row.len = 32'($urandom_range(48, 64));
            else
                row.len = 32'($urandom_range(65, 120));
            row.count  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 3));
            row.index  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 3));
            row.pinned   = 1'b0;
            row.msg_end  = 1'b0;
            row.call_end = 1'b0;
            row.bad      = 1'b0;
            send_message(row, $urandom_range(0, 4) == 0, sent);
            rand_bytes += sent;
            n_msgs++;
        end

        // short length trips malformed; trailing bytes must only pass through
        send_message(plan[N_ROWS-1], 1'b0, sent);
        for (k = 0; k < NOISE_BYTES; k++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d beats: %0d message ends, %0d call ends, %0d flagged malformed",
                 beats_checked, msg_ends_seen, call_ends_seen, bad_beats_seen);
        $display("Directed edge messages, %0d random messages, short header with noise",
                 n_msgs);
        if (mismatches == 0 && framed_bytes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d beats owed", mismatches, framed_bytes.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
